// File: hw/rtl/two_level_local_branch_predictor_defines.svh
// ----------------------------------------------------------------------------
// Two-level local branch predictor: assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef TWO_LEVEL_LOCAL_BRANCH_PREDICTOR_DEFINES_SVH
`define TWO_LEVEL_LOCAL_BRANCH_PREDICTOR_DEFINES_SVH

// Clocked assertion, suspended while reset is high
`define TLLBP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset
`define TLLBP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/tllbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tllbp_pkg
// Constants and controller/datapath interface types of the local predictor.
// ----------------------------------------------------------------------------
package tllbp_pkg;

  // Table geometry (history table entries must be a power of two)
  localparam int HIST_ENTRIES = 16384;
  localparam int HIST_BITS    = 14;
  localparam int CTR_BITS     = 4;
  localparam int HSLOT_W      = $clog2(HIST_ENTRIES);
  localparam int PAT_ENTRIES  = 1 << HIST_BITS;

  // Clear sweep covers the larger of the two tables
  localparam int CLR_ENTRIES  = (HIST_ENTRIES > PAT_ENTRIES) ? HIST_ENTRIES : PAT_ENTRIES;
  localparam int CLR_W        = $clog2(CLR_ENTRIES);

  // Threshold register
  localparam int THR_W        = 4;
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(2);
  localparam int CMP_W        = (CTR_BITS > THR_W) ? CTR_BITS : THR_W;

  localparam logic [CTR_BITS-1:0] CTR_MAX = {CTR_BITS{1'b1}};

  // Request codes
  localparam logic CMD_PREDICT = 1'b0;
  localparam logic CMD_UPDATE  = 1'b1;

  // Configuration bus
  localparam int APB_ADDR_W = 2;
  localparam int APB_DATA_W = 32;

  // Controller to datapath
  typedef struct packed {
    logic clear;    // clear sweep step
    logic hist_rd;  // latch request, read history
    logic ctr_rd;   // read counter at history
    logic exec;     // predict or write back
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;
  } dp_sts_t;

endpackage

// File: hw/rtl/tllbp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tllbp_ctrl
// Sequencer: clear sweep after reset, then history read, counter read and
// execute for each accepted request.
// ----------------------------------------------------------------------------
module tllbp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  tllbp_pkg::dp_sts_t sts,
  output tllbp_pkg::dp_cmd_t cmd,
  output logic              busy
);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_HIST  = 4'b0100,
    ST_CTR   = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (sts.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_next = ST_HIST;
      end
      ST_HIST: begin
        state_next = ST_CTR;
      end
      ST_CTR: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd.clear   = (state == ST_CLEAR);
    cmd.hist_rd = (state == ST_IDLE) && start;
    cmd.ctr_rd  = (state == ST_HIST);
    cmd.exec    = (state == ST_CTR);
  end

  assign busy = (state != ST_IDLE);

endmodule

// File: hw/rtl/tllbp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tllbp_datapath
// History and counter tables, request registers, threshold register,
// counter update and registered prediction output.
// ----------------------------------------------------------------------------
module tllbp_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  tllbp_pkg::dp_cmd_t            cmd,
  output tllbp_pkg::dp_sts_t            sts,
  input  logic                          req_cmd,
  input  logic [63:0]                   req_ip,
  input  logic                          req_taken,
  input  logic                          thr_we,
  input  logic [tllbp_pkg::THR_W-1:0]   thr_wdata,
  output logic [tllbp_pkg::THR_W-1:0]   thr,
  output logic                          done,
  output logic                          predict_taken
);

  // Tables
  logic [tllbp_pkg::HIST_BITS-1:0] hist_mem [tllbp_pkg::HIST_ENTRIES];
  logic [tllbp_pkg::CTR_BITS-1:0]  ctr_mem  [tllbp_pkg::PAT_ENTRIES];

  // Request registers
  logic                             cmd_q;
  logic                             taken_q;
  logic [tllbp_pkg::HSLOT_W-1:0]    hslot_q;
  logic [tllbp_pkg::HIST_BITS-1:0]  hist_q;
  logic [tllbp_pkg::CTR_BITS-1:0]   ctr_q;

  logic [tllbp_pkg::CLR_W-1:0]      clr_idx;

  logic                             hist_we;
  logic [tllbp_pkg::HSLOT_W-1:0]    hist_waddr;
  logic [tllbp_pkg::HIST_BITS-1:0]  hist_wdata;
  logic                             ctr_we;
  logic [tllbp_pkg::HIST_BITS-1:0]  ctr_waddr;
  logic [tllbp_pkg::CTR_BITS-1:0]   ctr_wdata;
  logic [tllbp_pkg::CTR_BITS-1:0]   ctr_new;
  logic                             clr_in_hist;
  logic                             clr_in_ctr;
  logic                             upd;
  logic                             pred;

  // Clear sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clear) begin
      clr_idx <= clr_idx + tllbp_pkg::CLR_W'(1);
    end
  end

  assign sts.clear_last = (clr_idx == tllbp_pkg::CLR_W'(tllbp_pkg::CLR_ENTRIES - 1));
  assign clr_in_hist = ({1'b0, clr_idx} < (tllbp_pkg::CLR_W + 1)'(tllbp_pkg::HIST_ENTRIES));
  assign clr_in_ctr  = ({1'b0, clr_idx} < (tllbp_pkg::CLR_W + 1)'(tllbp_pkg::PAT_ENTRIES));

  // Threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= tllbp_pkg::THR_RESET;
    end else if (thr_we) begin
      thr <= thr_wdata;
    end
  end

  // Latch the request and read its history entry
  always_ff @(posedge clk) begin
    if (cmd.hist_rd) begin
      cmd_q   <= req_cmd;
      taken_q <= req_taken;
      hslot_q <= req_ip[tllbp_pkg::HSLOT_W-1:0];
      hist_q  <= hist_mem[req_ip[tllbp_pkg::HSLOT_W-1:0]];
    end
  end

  // Counter read, indexed by the history
  always_ff @(posedge clk) begin
    if (cmd.ctr_rd) begin
      ctr_q <= ctr_mem[hist_q];
    end
  end

  // Saturating counter step toward the outcome
  always_comb begin
    if (taken_q) begin
      ctr_new = (ctr_q == tllbp_pkg::CTR_MAX) ? ctr_q : ctr_q + tllbp_pkg::CTR_BITS'(1);
    end else begin
      ctr_new = (ctr_q == '0) ? ctr_q : ctr_q - tllbp_pkg::CTR_BITS'(1);
    end
  end

  assign upd  = cmd.exec && (cmd_q == tllbp_pkg::CMD_UPDATE);
  assign pred = (tllbp_pkg::CMP_W'(ctr_q) >= tllbp_pkg::CMP_W'(thr));

  // Write port selection: clear sweep or update write-back
  always_comb begin
    if (cmd.clear) begin
      hist_we    = clr_in_hist;
      hist_waddr = clr_idx[tllbp_pkg::HSLOT_W-1:0];
      hist_wdata = '0;
      ctr_we     = clr_in_ctr;
      ctr_waddr  = clr_idx[tllbp_pkg::HIST_BITS-1:0];
      ctr_wdata  = '0;
    end else begin
      hist_we    = upd;
      hist_waddr = hslot_q;
      hist_wdata = {taken_q, hist_q[tllbp_pkg::HIST_BITS-1:1]};
      ctr_we     = upd;
      ctr_waddr  = hist_q;
      ctr_wdata  = ctr_new;
    end
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_waddr] <= hist_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctr_we) begin
      ctr_mem[ctr_waddr] <= ctr_wdata;
    end
  end

  // Result strobe and prediction
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.exec && (cmd_q == tllbp_pkg::CMD_PREDICT);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      predict_taken <= pred;
    end
  end

endmodule

// File: hw/rtl/two_level_local_branch_predictor.sv
`timescale 1ns / 1ps
// Result: a predict result strobes on done, registered from the execute step.
// Requests: one at a time; a new one is not taken until the history read, then
// the counter read it indexes, then the write-back or prediction are through.
// Reset: after rst both tables are swept to zero, with busy high throughout.
// The receiver cannot stall: done marks a result for exactly one cycle.
// ----------------------------------------------------------------------------
// two_level_local_branch_predictor
// Local history branch predictor with command-style request port and an
// APB-style register port for the taken threshold.
// ----------------------------------------------------------------------------
module two_level_local_branch_predictor (
  input  logic                                clk,
  input  logic                                rst,
  // Request port
  input  logic                                start,
  output logic                                busy,
  input  logic                                cmd,
  input  logic [63:0]                         ip,
  input  logic                                taken,
  // Result port
  output logic                                done,
  output logic                                predict_taken,
  // Register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tllbp_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [tllbp_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [tllbp_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                pready
);

  tllbp_pkg::dp_cmd_t           dp_cmd;
  tllbp_pkg::dp_sts_t           dp_sts;
  logic                         thr_we;
  logic [tllbp_pkg::THR_W-1:0]  thr;

  // Register decode: the threshold is the only register
  assign pready = 1'b1;
  assign thr_we = psel && penable && pwrite && pready
                  && (paddr == tllbp_pkg::APB_ADDR_W'(0));
  assign prdata = tllbp_pkg::APB_DATA_W'(thr);

  tllbp_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (dp_sts),
    .cmd   (dp_cmd),
    .busy  (busy)
  );

  tllbp_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (dp_cmd),
    .sts           (dp_sts),
    .req_cmd       (cmd),
    .req_ip        (ip),
    .req_taken     (taken),
    .thr_we        (thr_we),
    .thr_wdata     (pwdata[tllbp_pkg::THR_W-1:0]),
    .thr           (thr),
    .done          (done),
    .predict_taken (predict_taken)
  );

endmodule

// File: hw/rtl/tllbp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tllbp_checker
// Port-level checks of request/result timing, bound to the top level.
// ----------------------------------------------------------------------------
`include "two_level_local_branch_predictor_defines.svh"

module tllbp_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic cmd,
  input logic done
);

  // A result never shows while a request is in flight
  `TLLBP_ASSERT_ALWAYS(a_done_idle, clk, done |-> !busy, "result while busy")

  // An accepted request keeps the block busy through the counter read and execute states
  `TLLBP_ASSERT(a_busy_span, clk, rst, (start && !busy) |=> busy ##1 busy ##1 !busy, "busy span wrong")

  // Every predict transaction gives a result after the counter read and execute states
  `TLLBP_ASSERT(a_pred_result, clk, rst, (start && !busy && (cmd == tllbp_pkg::CMD_PREDICT)) |-> ##3 done, "missing prediction")

  // Every result comes from an earlier accepted predict transaction
  `TLLBP_ASSERT(a_result_src, clk, rst, done |-> $past(start && !busy && (cmd == tllbp_pkg::CMD_PREDICT), 3), "spurious result")

endmodule

bind two_level_local_branch_predictor tllbp_checker u_tllbp_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .cmd   (cmd),
  .done  (done)
);
